@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the day-count block.
// Needs no other file; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low asynchronous reset.
`define DBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbd: same-cycle check failed");

// Next-cycle implication under an active-low asynchronous reset.
`define DBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbd: next-cycle check failed");

`endif

@@ design/dbd_pkg.sv @@
// Package for the day-count block: field widths, calendar constants and
// the month tables. Depends on nothing.
package dbd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // Biased March-based year and intermediate widths.
    localparam int YY_W   = 15;
    localparam int PROD_W = 27;
    localparam int Q_W    = 8;
    localparam int OFF_W  = 9;
    localparam int DOFF_W = 10;

    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [YY_W-1:0]    YEAR_BIAS     = 15'd400;
    localparam logic [12:0]        DIV100_MUL    = 13'd5243;
    localparam int                 DIV100_SHIFT  = 19;
    localparam logic [6:0]         CENTURY       = 7'd100;
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [Q_W-1:0]     CENTURY_BIAS  = 8'd4;
    localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 22'd3652424;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    // Days in each month of a common year; codes outside 1..12 give zero,
    // so they can never pass the day check.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a year that starts on March 1.
    function automatic logic [OFF_W-1:0] month_off(input logic [MONTH_W-1:0] m);
        logic [OFF_W-1:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

@@ design/days_between_dates.sv @@
// Top level of the day-count block: a four-stage pipeline that turns two
// Gregorian dates into the absolute number of days between them.
// Depends on dbd_pkg.sv and assert_macros.svh.
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | first_day/month/year, second_day/month/year
//  output  | out_valid / out_stall| day_count, date_invalid
//
// One word enters per cycle unless in_stall is high. Its result passes
// through the four register stages in turn (year divide, calendar checks,
// day numbers, difference) and leaves on the output channel.
// Reset clears only the stage valid bits; no data is held over.
// A stall on the output freezes the last stage; earlier stages keep moving
// into empty slots, so in_stall rises only when all four stages are full.
`include "assert_macros.svh"

module days_between_dates
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [dbd_pkg::DAY_W-1:0]     first_day,
    input  logic [dbd_pkg::MONTH_W-1:0]   first_month,
    input  logic [dbd_pkg::YEAR_W-1:0]    first_year,
    input  logic [dbd_pkg::DAY_W-1:0]     second_day,
    input  logic [dbd_pkg::MONTH_W-1:0]   second_month,
    input  logic [dbd_pkg::YEAR_W-1:0]    second_year,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [dbd_pkg::COUNT_W-1:0]   day_count,
    output logic                          date_invalid
);

    // Stage valid bits and per-stage load enables. A stage loads when it is
    // empty or when the stage after it is loading this cycle.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // Input words as two lanes, one per date.
    dbd_pkg::date_t date_in [2];

    assign date_in[0] = '{day: first_day,  month: first_month,  year: first_year};
    assign date_in[1] = '{day: second_day, month: second_month, year: second_year};

    // Stage 1: the date itself and year / 100 by a reciprocal multiply.
    // The reciprocal is exact for every 14-bit year.
    dbd_pkg::date_t            s1_date_reg [2];
    logic [dbd_pkg::Q_W-1:0]   s1_cent_reg [2];
    logic [dbd_pkg::Q_W-1:0]   s1_cent_next [2];

    // Stage 2: date check, biased March-based year and its century count.
    logic [dbd_pkg::YY_W-1:0]   s2_yy_reg [2];
    logic [dbd_pkg::YY_W-1:0]   s2_yy_next [2];
    logic [dbd_pkg::Q_W-1:0]    s2_cy_reg [2];
    logic [dbd_pkg::Q_W-1:0]    s2_cy_next [2];
    logic [dbd_pkg::DOFF_W-1:0] s2_doff_reg [2];
    logic [dbd_pkg::DOFF_W-1:0] s2_doff_next [2];
    logic                       s2_bad_reg;
    logic                       s2_bad_next;

    // Stage 3: day number of each date.
    logic [dbd_pkg::COUNT_W-1:0] s3_num_reg [2];
    logic [dbd_pkg::COUNT_W-1:0] s3_num_next [2];
    logic                        s3_bad_reg;

    // Stage 4: output register.
    logic [dbd_pkg::COUNT_W-1:0] count_reg;
    logic [dbd_pkg::COUNT_W-1:0] count_next;
    logic                        bad_reg;

    always_comb
    begin
        logic [dbd_pkg::PROD_W-1:0] prod;
        for (int i = 0; i < 2; i++)
        begin
            prod = dbd_pkg::PROD_W'(date_in[i].year) * dbd_pkg::PROD_W'(dbd_pkg::DIV100_MUL);
            s1_cent_next[i] = prod[dbd_pkg::DIV100_SHIFT +: dbd_pkg::Q_W];
        end
    end

    // Leap rule: divisible by 4, and not a century year unless the century
    // count is itself divisible by 4. The year shift for January and
    // February moves the century count down by one only on a century year.
    always_comb
    begin
        logic                        cent_year;
        logic                        leap;
        logic                        early;
        logic [dbd_pkg::DAY_W:0]     len;
        logic                        ok;
        logic [1:0]                  ok_lane;
        for (int i = 0; i < 2; i++)
        begin
            cent_year = (dbd_pkg::YY_W'(s1_date_reg[i].year)
                         == dbd_pkg::YY_W'(s1_cent_reg[i]) * dbd_pkg::YY_W'(dbd_pkg::CENTURY));
            leap  = (s1_date_reg[i].year[1:0] == 2'd0)
                    && (!cent_year || (s1_cent_reg[i][1:0] == 2'd0));
            early = (s1_date_reg[i].month <= dbd_pkg::FEBRUARY);
            len   = {1'b0, dbd_pkg::month_len(s1_date_reg[i].month)}
                    + ((s1_date_reg[i].month == dbd_pkg::FEBRUARY && leap) ? 6'd1 : 6'd0);
            ok    = (s1_date_reg[i].day != '0)
                    && ({1'b0, s1_date_reg[i].day} <= len)
                    && (s1_date_reg[i].year <= dbd_pkg::YEAR_MAX);
            ok_lane[i] = ok;
            s2_yy_next[i] = dbd_pkg::YY_W'(s1_date_reg[i].year) + dbd_pkg::YEAR_BIAS
                            - dbd_pkg::YY_W'(early);
            s2_cy_next[i] = s1_cent_reg[i] + dbd_pkg::CENTURY_BIAS
                            - dbd_pkg::Q_W'(early && cent_year);
            s2_doff_next[i] = dbd_pkg::DOFF_W'(dbd_pkg::month_off(s1_date_reg[i].month))
                              + dbd_pkg::DOFF_W'(s1_date_reg[i].day);
        end
        s2_bad_next = !(ok_lane[0] && ok_lane[1]);
    end

    // Day number: 365 * yy + yy/4 - yy/100 + yy/400 + month offset + day.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s3_num_next[i] = dbd_pkg::COUNT_W'(s2_yy_reg[i]) * dbd_pkg::COUNT_W'(dbd_pkg::DAYS_PER_YEAR)
                             + dbd_pkg::COUNT_W'(s2_yy_reg[i] >> 2)
                             - dbd_pkg::COUNT_W'(s2_cy_reg[i])
                             + dbd_pkg::COUNT_W'(s2_cy_reg[i] >> 2)
                             + dbd_pkg::COUNT_W'(s2_doff_reg[i]);
        end
    end

    always_comb
    begin
        if (s3_bad_reg)
        begin
            count_next = '0;
        end
        else if (s3_num_reg[0] >= s3_num_reg[1])
        begin
            count_next = s3_num_reg[0] - s3_num_reg[1];
        end
        else
        begin
            count_next = s3_num_reg[1] - s3_num_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_date_reg <= date_in;
            s1_cent_reg <= s1_cent_next;
        end
        if (en2 && v1_reg)
        begin
            s2_yy_reg   <= s2_yy_next;
            s2_cy_reg   <= s2_cy_next;
            s2_doff_reg <= s2_doff_next;
            s2_bad_reg  <= s2_bad_next;
        end
        if (en3 && v2_reg)
        begin
            s3_num_reg <= s3_num_next;
            s3_bad_reg <= s2_bad_reg;
        end
        if (en4 && v3_reg)
        begin
            count_reg <= count_next;
            bad_reg   <= s3_bad_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign day_count    = count_reg;
    assign date_invalid = bad_reg;

    // An accepted word always lands in the first stage.
    `DBD_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, v1_reg)
    // Back-pressure reaches the input only when every stage is occupied.
    `DBD_ASSERT_IMPLY(a_stall_full, clk, rst_n, in_stall, v1_reg && v2_reg && v3_reg && v4_reg)
    // A rejected pair never carries a count.
    `DBD_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, out_valid && date_invalid, day_count == '0)
    // The count never exceeds the span of years 0 to 9999.
    `DBD_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid, day_count <= dbd_pkg::COUNT_MAX)

endmodule

@@ test/days_between_dates_tb.sv @@
// Testbench for days_between_dates: directed and random date pairs with idle and stall gaps.
// Depends on dbd_pkg.sv and the days_between_dates RTL. It reads no files.
// A scoreboard predicts each day count and checks the results in order.
module days_between_dates_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // About 1750 random pairs follow the directed set. The block has a
    // four-stage pipeline, and the settling wait outlasts that pipeline.
    localparam int    RANDOM_PAIRS  = 1750;
    localparam int    SETTLE_CYCLES = 12;
    localparam int    RESET_CYCLES  = 5;
    // Worst case is about 1800 words, each waiting out a long sender gap
    // and a long output stall. That is roughly 2.6 ms, and the limit allows
    // several times as much.
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // The scoreboard keeps its own calendar arithmetic. A date becomes an
    // ordinal day count from 1 January of year 0. The difference of two
    // ordinals is the span. Any invalid date in a pair gives a zero count
    // with the flag set.
    class span_board;
        typedef struct {
            logic [dbd_pkg::COUNT_W-1:0] count;
            logic                        bad;
        } span_t;

        span_t pending[$];
        int    errors;
        int    checked;
        int    flagged;

        function new();
            errors  = 0;
            checked = 0;
            flagged = 0;
        endfunction

        static function bit leap(int unsigned yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        // Month length in the given year. Month codes outside 1..12 give zero.
        static function int unsigned month_days(logic [dbd_pkg::MONTH_W-1:0] mon,
                                                logic [dbd_pkg::YEAR_W-1:0] yr);
            int unsigned len;
            case (mon)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 30;
                dbd_pkg::FEBRUARY:                          len = leap(32'(yr)) ? 29 : 28;
                default:                                    len = 0;
            endcase
            return len;
        endfunction

        static function bit valid_date(dbd_pkg::date_t dt);
            return dt.month >= 1 && dt.month <= 12 && dt.year <= dbd_pkg::YEAR_MAX &&
                   dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
        endfunction

        static function int unsigned ordinal(dbd_pkg::date_t dt);
            int unsigned month_start[12] = '{0, 31, 59, 90, 120, 151,
                                             181, 212, 243, 273, 304, 334};
            int unsigned yr;
            int unsigned year_days;
            yr = 32'(dt.year);
            // Year 0 is a leap year. Count the leap years in 0..yr-1.
            year_days = yr * 365;
            if (yr > 0)
                year_days += (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 + 1;
            year_days += month_start[dt.month - 1];
            if (dt.month > dbd_pkg::FEBRUARY && leap(yr))
                year_days += 1;
            return year_days + 32'(dt.day);
        endfunction

        function void note_pair(dbd_pkg::date_t a, dbd_pkg::date_t b);
            span_t       s;
            int unsigned na;
            int unsigned nb;
            s.count = '0;
            s.bad   = 1'b1;
            if (valid_date(a) && valid_date(b))
            begin
                na      = ordinal(a);
                nb      = ordinal(b);
                s.count = dbd_pkg::COUNT_W'((na > nb) ? na - nb : nb - na);
                s.bad   = 1'b0;
            end
            pending.insert(pending.size(), s);
        endfunction

        function void check_span(logic [dbd_pkg::COUNT_W-1:0] count, logic bad);
            span_t s;
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected: day_count %0d date_invalid %0b",
                         $realtime, count, bad);
                errors++;
                return;
            end
            s = pending.pop_front();
            checked++;
            if (s.bad)
                flagged++;
            if (count !== s.count)
            begin
                $display("%0t: day_count expected %0d actual %0d", $realtime, s.count, count);
                errors++;
            end
            if (bad !== s.bad)
            begin
                $display("%0t: date_invalid expected %0b actual %0b", $realtime, s.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [dbd_pkg::DAY_W-1:0]     first_day    = '0;
    logic [dbd_pkg::MONTH_W-1:0]   first_month  = '0;
    logic [dbd_pkg::YEAR_W-1:0]    first_year   = '0;
    logic [dbd_pkg::DAY_W-1:0]     second_day   = '0;
    logic [dbd_pkg::MONTH_W-1:0]   second_month = '0;
    logic [dbd_pkg::YEAR_W-1:0]    second_year  = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic [dbd_pkg::COUNT_W-1:0]   day_count;
    logic                          date_invalid;

    span_board board;
    int        words_sent = 0;

    days_between_dates u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .day_count    (day_count),
        .date_invalid (date_invalid)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length in cycles. Most gaps are zero or short and a few are long.
    // A calm phase has no gaps at all.
    function automatic int pick_idle(bit calm);
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 85)
            return $urandom_range(2, 1);
        if (roll < 97)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    function automatic dbd_pkg::date_t mk(int unsigned d, int unsigned m, int unsigned y);
        dbd_pkg::date_t dt;
        dt.day   = dbd_pkg::DAY_W'(d);
        dt.month = dbd_pkg::MONTH_W'(m);
        dt.year  = dbd_pkg::YEAR_W'(y);
        return dt;
    endfunction

    function automatic dbd_pkg::date_t valid_in_year(int unsigned y);
        dbd_pkg::date_t dt;
        dt.year  = dbd_pkg::YEAR_W'(y);
        dt.month = dbd_pkg::MONTH_W'($urandom_range(12, 1));
        dt.day   = dbd_pkg::DAY_W'($urandom_range(span_board::month_days(dt.month, dt.year), 1));
        return dt;
    endfunction

    // Dates near calendar edges: century, 400-year and leap years, the ends of
    // the year range or any year, and the first or last day of a month.
    function automatic dbd_pkg::date_t boundary_date();
        dbd_pkg::date_t dt;
        int unsigned    y;
        case ($urandom_range(5))
            0:       y = 0;
            1:       y = 32'(dbd_pkg::YEAR_MAX);
            2:       y = $urandom_range(99) * 100;
            3:       y = $urandom_range(24) * 400;
            4:       y = $urandom_range(2499) * 4;
            default: y = $urandom_range(dbd_pkg::YEAR_MAX);
        endcase
        dt = valid_in_year(y);
        if ($urandom_range(3) == 0)
            dt.month = dbd_pkg::FEBRUARY;
        dt.day = $urandom_range(1)
                 ? dbd_pkg::DAY_W'(span_board::month_days(dt.month, dt.year))
                 : dbd_pkg::DAY_W'(1);
        return dt;
    endfunction

    // A date close to the given one, so that short spans get exercised.
    function automatic dbd_pkg::date_t near_date(dbd_pkg::date_t base);
        int y;
        y = int'(base.year) + $urandom_range(6) - 3;
        if (y < 0)
            y = 0;
        if (y > int'(dbd_pkg::YEAR_MAX))
            y = int'(dbd_pkg::YEAR_MAX);
        return valid_in_year(y);
    endfunction

    // Raw field bits with no limits. Most of these dates are invalid.
    function automatic dbd_pkg::date_t noisy_date();
        dbd_pkg::date_t dt;
        dt.day   = dbd_pkg::DAY_W'($urandom_range(31));
        dt.month = dbd_pkg::MONTH_W'($urandom_range(15));
        dt.year  = dbd_pkg::YEAR_W'($urandom_range(16383));
        return dt;
    endfunction

    // Present one word and hold it until the block takes it. Values are
    // sampled just after the edge, so in_valid and in_stall are the values
    // that the edge saw. A word with no gap before it is driven at the same
    // step that the previous word is accepted.
    task automatic send_pair(dbd_pkg::date_t a, dbd_pkg::date_t b, int idle);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_day    <= a.day;
        first_month  <= a.month;
        first_year   <= a.year;
        second_day   <= b.day;
        second_month <= b.month;
        second_year  <= b.year;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pair(a, b);
        words_sent++;
    endtask

    // Output side: accept a result when out_valid is high and out_stall is
    // low at the edge. Both are sampled before that edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_span(day_count, date_invalid);
    end

    // Output stall pattern. Runs with no stall alternate with stall bursts.
    // Now and then a long calm stretch lets the pipeline run at full rate.
    initial
    begin
        int calm_run;
        int hold;
        wait (rst_n);
        forever
        begin
            calm_run = ($urandom_range(9) == 0) ? $urandom_range(300, 100)
                                                : $urandom_range(12, 1);
            repeat (calm_run) @(posedge clk);
            hold = pick_idle(1'b0);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        dbd_pkg::date_t a;
        dbd_pkg::date_t b;
        int             kind;
        bit             calm;

        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pairs. They cover equal dates, the widest span in both
        // orders, and leap days in 400-year, century, ordinary and common
        // years. They also cover day zero, days past the month end, bad
        // months, out-of-range years, and a second date that alone is bad.
        send_pair(mk(1, 1, 0),      mk(1, 1, 0),        pick_idle(1'b0));
        send_pair(mk(1, 1, 0),      mk(31, 12, 9999),   pick_idle(1'b0));
        send_pair(mk(31, 12, 9999), mk(1, 1, 0),        pick_idle(1'b0));
        send_pair(mk(15, 6, 2024),  mk(15, 6, 2024),    pick_idle(1'b0));
        send_pair(mk(29, 2, 2000),  mk(1, 3, 2000),     pick_idle(1'b0));
        send_pair(mk(29, 2, 1900),  mk(1, 1, 1900),     pick_idle(1'b0));
        send_pair(mk(29, 2, 2004),  mk(28, 2, 2005),    pick_idle(1'b0));
        send_pair(mk(29, 2, 2001),  mk(1, 1, 2001),     pick_idle(1'b0));
        send_pair(mk(29, 2, 0),     mk(1, 3, 0),        pick_idle(1'b0));
        send_pair(mk(0, 5, 100),    mk(1, 5, 100),      pick_idle(1'b0));
        send_pair(mk(31, 4, 2010),  mk(1, 1, 2010),     pick_idle(1'b0));
        send_pair(mk(30, 2, 2000),  mk(1, 1, 2000),     pick_idle(1'b0));
        send_pair(mk(1, 0, 500),    mk(1, 1, 500),      pick_idle(1'b0));
        send_pair(mk(1, 13, 500),   mk(1, 1, 500),      pick_idle(1'b0));
        send_pair(mk(31, 15, 16383), mk(1, 1, 1),       pick_idle(1'b0));
        send_pair(mk(1, 1, 10000),  mk(1, 1, 9999),     pick_idle(1'b0));
        send_pair(mk(1, 1, 1),      mk(1, 1, 16383),    pick_idle(1'b0));
        send_pair(mk(28, 2, 1900),  mk(1, 3, 1900),     pick_idle(1'b0));
        send_pair(mk(31, 12, 1999), mk(1, 1, 2000),     pick_idle(1'b0));
        send_pair(mk(1, 3, 9999),   mk(28, 2, 9999),    pick_idle(1'b0));
        send_pair(mk(31, 1, 5000),  mk(0, 0, 0),        pick_idle(1'b0));

        // Random pairs. Most are valid dates: uniform, near boundaries, or
        // close together. The rest carry raw field bits, so every input bit
        // takes both values. Every third block of 250 words runs with no
        // sender gaps.
        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            calm = ((i / 250) % 3 == 1);
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                a = valid_in_year($urandom_range(dbd_pkg::YEAR_MAX));
                b = valid_in_year($urandom_range(dbd_pkg::YEAR_MAX));
            end
            else if (kind < 65)
            begin
                a = boundary_date();
                b = boundary_date();
            end
            else if (kind < 80)
            begin
                a = valid_in_year($urandom_range(dbd_pkg::YEAR_MAX));
                b = near_date(a);
            end
            else if (kind < 90)
            begin
                a = noisy_date();
                b = valid_in_year($urandom_range(dbd_pkg::YEAR_MAX));
                if ($urandom_range(1))
                begin
                    b = a;
                    a = valid_in_year($urandom_range(dbd_pkg::YEAR_MAX));
                end
            end
            else
            begin
                a = noisy_date();
                b = noisy_date();
            end
            send_pair(a, b, pick_idle(calm));
        end
        in_valid <= 1'b0;

        // Drain the pipeline. Then wait a little longer so that any stray
        // extra result is caught.
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d date pairs and checked %0d results, %0d of them flagged invalid.",
                 words_sent, board.checked, board.flagged);
        if (board.errors == 0)
            $display("days_between_dates test passed");
        else
            $display("days_between_dates test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Timed out with %0d results still expected.", board.pending.size());
        $display("days_between_dates test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/dbd_pkg.sv
design/days_between_dates.sv
test/days_between_dates_tb.sv
